### rtl/qad_pkg.sv
// ----------------------------------------------------------------------------
// qad_pkg: shared types and constants of the quaternion angular distance unit
// Fixed-point widths of the normalized datapath, the square-root and CORDIC
// cell payloads, and the CORDIC arctangent constants.
// ----------------------------------------------------------------------------
package qad_pkg;

    localparam int COMPONENT_BITS_DEF = 16;
    localparam int CORDIC_STAGES_DEF  = 16;

    // The largest magnitude is normalized so that its top set bit lands here.
    localparam int NORM_TOP     = 29;
    localparam int NORM_BITS    = NORM_TOP + 1;
    localparam int SQRT_IN_BITS = 2 * NORM_BITS + 2;
    localparam int ROOT_BITS    = SQRT_IN_BITS / 2;
    localparam int REM_BITS     = ROOT_BITS + 2;

    // Angle accumulator is Q2.30; x and y need two guard bits over 2^31.
    localparam int ATAN_FRAC    = 30;
    localparam int ATAN_BITS    = 30;
    localparam int CORDIC_BITS  = 34;

    localparam int ANGLE_BITS   = 16;
    localparam int ROUND_BIT    = 14;
    localparam int ANGLE_SHIFT  = 15;
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 16'd51472;

    typedef struct packed {
        logic                    vld;
        logic                    zero;
        logic [SQRT_IN_BITS-1:0] n;
        logic [REM_BITS-1:0]     rem;
        logic [ROOT_BITS-1:0]    root;
        logic [NORM_BITS-1:0]    x;
    } t_sqrt_data;

    typedef struct packed {
        logic                          vld;
        logic                          zero;
        logic signed [CORDIC_BITS-1:0] x;
        logic signed [CORDIC_BITS-1:0] y;
        logic signed [CORDIC_BITS-1:0] z;
    } t_cordic_data;

    // atan(2^-i) in Q2.30, rounded to nearest.
    function automatic logic [ATAN_BITS-1:0] cordic_atan(input int i);
        logic [ATAN_BITS-1:0] res;
        case (i)
            0: res = 30'd843314857;
            1: res = 30'd497837829;
            2: res = 30'd263043837;
            3: res = 30'd133525159;
            4: res = 30'd67021687;
            5: res = 30'd33543516;
            6: res = 30'd16775851;
            7: res = 30'd8388437;
            8: res = 30'd4194283;
            9: res = 30'd2097149;
            default: begin
                if (i <= ATAN_FRAC) begin
                    res = ATAN_BITS'(1) << (ATAN_FRAC - i);
                end else begin
                    res = '0;
                end
            end
        endcase
        return res;
    endfunction

endpackage

### rtl/qad_if.sv
// ----------------------------------------------------------------------------
// qad_if: valid/ready channels of the quaternion angular distance unit
// qad_pair_if carries one pair of quaternions, qad_angle_if one angle.
// ----------------------------------------------------------------------------
interface qad_pair_if #(
    parameter int COMPONENT_BITS = qad_pkg::COMPONENT_BITS_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [COMPONENT_BITS-1:0] first_w;
    logic signed [COMPONENT_BITS-1:0] first_x;
    logic signed [COMPONENT_BITS-1:0] first_y;
    logic signed [COMPONENT_BITS-1:0] first_z;
    logic signed [COMPONENT_BITS-1:0] second_w;
    logic signed [COMPONENT_BITS-1:0] second_x;
    logic signed [COMPONENT_BITS-1:0] second_y;
    logic signed [COMPONENT_BITS-1:0] second_z;

    modport source (
        output valid, first_w, first_x, first_y, first_z,
               second_w, second_x, second_y, second_z,
        input  ready
    );
    modport sink (
        input  valid, first_w, first_x, first_y, first_z,
               second_w, second_x, second_y, second_z,
        output ready
    );
endinterface

interface qad_angle_if;
    logic                                 valid;
    logic                                 ready;
    logic [qad_pkg::ANGLE_BITS-1:0]       angle;

    modport source (output valid, angle, input ready);
    modport sink   (input valid, angle, output ready);
endinterface

### rtl/qad_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qad_sqrt_cell: one digit of the pipelined integer square root
// Brings in the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module qad_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  qad_pkg::t_sqrt_data i_d,
    output qad_pkg::t_sqrt_data o_d
);
    import qad_pkg::*;

    logic [REM_BITS+1:0] w_cur;
    logic [REM_BITS+1:0] w_trial;
    logic [REM_BITS+1:0] w_diff;
    t_sqrt_data          n_d;
    t_sqrt_data          r_d;

    always_comb begin
        w_cur   = {i_d.rem, i_d.n[SQRT_IN_BITS-1 -: 2]};
        w_trial = {2'b00, i_d.root, 2'b01};
        w_diff  = w_cur - w_trial;
        n_d     = i_d;
        n_d.n   = {i_d.n[SQRT_IN_BITS-3:0], 2'b00};
        if (w_cur >= w_trial) begin
            n_d.rem  = w_diff[REM_BITS-1:0];
            n_d.root = {i_d.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            n_d.rem  = w_cur[REM_BITS-1:0];
            n_d.root = {i_d.root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

### rtl/qad_cordic_cell.sv
// ----------------------------------------------------------------------------
// qad_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates (x, y) toward the x axis by atan(2^-STAGE) and tracks the angle.
// ----------------------------------------------------------------------------
module qad_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  qad_pkg::t_cordic_data i_d,
    output qad_pkg::t_cordic_data o_d
);
    import qad_pkg::*;

    localparam logic [CORDIC_BITS-1:0] ATAN = CORDIC_BITS'(cordic_atan(STAGE));

    logic signed [CORDIC_BITS-1:0] w_dx;
    logic signed [CORDIC_BITS-1:0] w_dy;
    t_cordic_data                  n_d;
    t_cordic_data                  r_d;

    always_comb begin
        // Arithmetic shifts round toward minus infinity.
        w_dx = $signed(i_d.y) >>> STAGE;
        w_dy = $signed(i_d.x) >>> STAGE;
        n_d  = i_d;
        if (!i_d.y[CORDIC_BITS-1] && (i_d.y != '0)) begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + $signed(ATAN);
        end else begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - $signed(ATAN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.vld <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

### rtl/quaternion_angular_distance.sv
// ----------------------------------------------------------------------------
// quaternion_angular_distance: rotation angle between two quaternions
// Forms s and v of q1 * conj(q2), normalizes them, takes |v| with a chain of
// square-root cells and 2*atan2(|v|, |s|) with a chain of CORDIC cells.
//
//   Channel  Dir  Payload                                  Width
//   i_pair   in   first_w..z, second_w..z (signed Q1.14)   8 x COMPONENT_BITS
//   o_dist   out  angle (unsigned Q2.14, 0 to pi)          16
//
// One pair is taken in every cycle while the skid register is empty. The path is
// nine front stages, one square-root cell per root bit (31), one CORDIC cell
// per stage and the output register. All stages move together and stop only
// while the skid register behind the output register is occupied. Reset
// clears every valid bit; no pass over storage is needed.
// ----------------------------------------------------------------------------
module quaternion_angular_distance #(
    parameter int COMPONENT_BITS = qad_pkg::COMPONENT_BITS_DEF,
    parameter int CORDIC_STAGES  = qad_pkg::CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qad_pair_if.sink          i_pair,
    qad_angle_if.source       o_dist
);
    import qad_pkg::*;

    localparam int PRE = (COMPONENT_BITS > 30) ? 1 : 0;
    localparam int W   = COMPONENT_BITS - PRE;
    localparam int PW  = 2 * W;
    localparam int SW  = PW + 2;
    localparam int TW  = $clog2(SW);
    localparam int FRONT_STAGES = 9;

    logic en;

    // Front stages.
    logic [FRONT_STAGES-1:0]     r_fv;
    logic signed [W-1:0]         r_qa [4];
    logic signed [W-1:0]         r_qb [4];
    logic signed [PW-1:0]        r_prod [4][4];
    logic signed [PW-1:0]        n_prod [4][4];
    logic signed [SW-1:0]        r_sum [4];
    logic signed [SW-1:0]        n_sum [4];
    logic [SW-1:0]               r_mag4 [4];
    logic [SW-1:0]               n_mag4 [4];
    logic [SW-1:0]               r_mag5 [4];
    logic [SW-1:0]               r_max;
    logic [SW-1:0]               n_max;
    logic [SW-1:0]               r_mag6 [4];
    logic [TW-1:0]               r_top;
    logic [TW-1:0]               n_top;
    logic                        r_zero6;
    logic [NORM_BITS-1:0]        r_norm [4];
    logic [NORM_BITS-1:0]        n_norm [4];
    logic                        r_zero7;
    logic [2*NORM_BITS-1:0]      r_sq [3];
    logic [2*NORM_BITS-1:0]      n_sq [3];
    logic [NORM_BITS-1:0]        r_as8;
    logic                        r_zero8;
    logic [SQRT_IN_BITS-1:0]     r_n;
    logic [NORM_BITS-1:0]        r_as9;
    logic                        r_zero9;

    // Cell chains.
    t_sqrt_data   w_sq [ROOT_BITS+1];
    t_cordic_data w_cd [CORDIC_STAGES+1];

    // Output register and skid register.
    logic                  r_out_vld;
    logic [ANGLE_BITS-1:0] r_out_angle;
    logic                  r_skid_vld;
    logic [ANGLE_BITS-1:0] r_skid_angle;
    logic [ANGLE_BITS-1:0] n_angle;
    logic                  w_take;
    logic                  w_new;

    assign en           = !r_skid_vld;
    assign i_pair.ready = en;

    always_comb begin
        for (int a = 0; a < 4; a++) begin
            for (int b = 0; b < 4; b++) begin
                n_prod[a][b] = PW'(r_qa[a]) * PW'(r_qb[b]);
            end
        end
    end

    // Indices: 0 = w, 1 = x, 2 = y, 3 = z; first index from q1, second from q2.
    always_comb begin
        n_sum[0] = SW'(r_prod[0][0]) + SW'(r_prod[1][1])
                 + SW'(r_prod[2][2]) + SW'(r_prod[3][3]);
        n_sum[1] = SW'(r_prod[1][0]) - SW'(r_prod[0][1])
                 - (SW'(r_prod[2][3]) - SW'(r_prod[3][2]));
        n_sum[2] = SW'(r_prod[2][0]) - SW'(r_prod[0][2])
                 - (SW'(r_prod[3][1]) - SW'(r_prod[1][3]));
        n_sum[3] = SW'(r_prod[3][0]) - SW'(r_prod[0][3])
                 - (SW'(r_prod[1][2]) - SW'(r_prod[2][1]));
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_mag4[k] = r_sum[k][SW-1] ? (~$unsigned(r_sum[k]) + SW'(1))
                                       : $unsigned(r_sum[k]);
        end
    end

    always_comb begin
        logic [SW-1:0] m01;
        logic [SW-1:0] m23;
        m01   = (r_mag4[0] > r_mag4[1]) ? r_mag4[0] : r_mag4[1];
        m23   = (r_mag4[2] > r_mag4[3]) ? r_mag4[2] : r_mag4[3];
        n_max = (m01 > m23) ? m01 : m23;
    end

    // Position of the highest set bit of the largest magnitude.
    always_comb begin
        n_top = '0;
        for (int k = 0; k < SW; k++) begin
            if (r_max[k]) begin
                n_top = TW'(k);
            end
        end
    end

    // Scale all four so that the largest has its top bit at NORM_TOP; bits
    // shifted out on the right are dropped.
    always_comb begin
        logic [SW+NORM_TOP-1:0] ext;
        logic [SW+NORM_TOP-1:0] shifted;
        for (int k = 0; k < 4; k++) begin
            ext       = {r_mag6[k], {NORM_TOP{1'b0}}};
            shifted   = ext >> r_top;
            n_norm[k] = shifted[NORM_BITS-1:0];
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sq[k] = (2*NORM_BITS)'(r_norm[k+1]) * (2*NORM_BITS)'(r_norm[k+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (en) begin
            r_fv <= {r_fv[FRONT_STAGES-2:0], i_pair.valid};

            r_qa[0] <= i_pair.first_w[COMPONENT_BITS-1:PRE];
            r_qa[1] <= i_pair.first_x[COMPONENT_BITS-1:PRE];
            r_qa[2] <= i_pair.first_y[COMPONENT_BITS-1:PRE];
            r_qa[3] <= i_pair.first_z[COMPONENT_BITS-1:PRE];
            r_qb[0] <= i_pair.second_w[COMPONENT_BITS-1:PRE];
            r_qb[1] <= i_pair.second_x[COMPONENT_BITS-1:PRE];
            r_qb[2] <= i_pair.second_y[COMPONENT_BITS-1:PRE];
            r_qb[3] <= i_pair.second_z[COMPONENT_BITS-1:PRE];

            r_prod  <= n_prod;
            r_sum   <= n_sum;
            r_mag4  <= n_mag4;
            r_mag5  <= r_mag4;
            r_max   <= n_max;
            r_mag6  <= r_mag5;
            r_top   <= n_top;
            r_zero6 <= (r_max == '0);
            r_norm  <= n_norm;
            r_zero7 <= r_zero6;
            r_sq    <= n_sq;
            r_as8   <= r_norm[0];
            r_zero8 <= r_zero7;
            r_n     <= SQRT_IN_BITS'(r_sq[0]) + SQRT_IN_BITS'(r_sq[1])
                     + SQRT_IN_BITS'(r_sq[2]);
            r_as9   <= r_as8;
            r_zero9 <= r_zero8;
        end
    end

    // |v| = floor(sqrt(vx^2 + vy^2 + vz^2)), one root bit per cell.
    always_comb begin
        w_sq[0]      = '0;
        w_sq[0].vld  = r_fv[FRONT_STAGES-1];
        w_sq[0].zero = r_zero9;
        w_sq[0].n    = r_n;
        w_sq[0].x    = r_as9;
    end

    for (genvar g = 0; g < ROOT_BITS; g++) begin : g_sqrt
        qad_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_sq[g]),
            .o_d     (w_sq[g+1])
        );
    end

    always_comb begin
        w_cd[0].vld  = w_sq[ROOT_BITS].vld;
        w_cd[0].zero = w_sq[ROOT_BITS].zero;
        w_cd[0].x    = {{(CORDIC_BITS-NORM_BITS){1'b0}}, w_sq[ROOT_BITS].x};
        w_cd[0].y    = {{(CORDIC_BITS-ROOT_BITS){1'b0}}, w_sq[ROOT_BITS].root};
        w_cd[0].z    = '0;
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        qad_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_d     (w_cd[g]),
            .o_d     (w_cd[g+1])
        );
    end

    // Doubling the Q2.30 angle into Q2.14 with rounding half up, then clamping.
    always_comb begin
        logic [CORDIC_BITS:0]                 rnd;
        logic [CORDIC_BITS-ANGLE_SHIFT:0]     quo;
        rnd = {1'b0, w_cd[CORDIC_STAGES].z} + (CORDIC_BITS+1)'(1 << ROUND_BIT);
        quo = rnd[CORDIC_BITS:ANGLE_SHIFT];
        if (w_cd[CORDIC_STAGES].zero || w_cd[CORDIC_STAGES].z[CORDIC_BITS-1]) begin
            n_angle = '0;
        end else if (quo > (CORDIC_BITS-ANGLE_SHIFT+1)'(ANGLE_MAX)) begin
            n_angle = ANGLE_MAX;
        end else begin
            n_angle = quo[ANGLE_BITS-1:0];
        end
    end

    assign w_take = r_out_vld && o_dist.ready;
    assign w_new  = en && w_cd[CORDIC_STAGES].vld;

    // A result that finds the output register busy waits in the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out_angle <= r_skid_angle;
                r_skid_vld  <= 1'b0;
            end
        end else if (w_new) begin
            if (!r_out_vld || w_take) begin
                r_out_angle <= n_angle;
                r_out_vld   <= 1'b1;
            end else begin
                r_skid_angle <= n_angle;
                r_skid_vld   <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_dist.valid = r_out_vld;
    assign o_dist.angle = r_out_angle;

endmodule
